// ===== hdl/lgs_pkg.sv =====
// Package for the life grid stepper: command codes, register indexes,
// controller states, datapath operations and the status struct.
// No dependencies.
package lgs_pkg;

    localparam int MAX_ROWS_DEF = 64;
    localparam int MAX_COLS_DEF = 64;

    localparam int CMD_W  = 2;
    localparam int ROW_W  = 6;
    localparam int COL_W  = 6;
    localparam int CFG_W  = 7;
    localparam int CFG_IW = 1;

    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_STEP  = 2'd2;

    localparam logic [CFG_IW-1:0] CFG_GRID_ROWS = 1'd0;
    localparam logic [CFG_IW-1:0] CFG_GRID_COLS = 1'd1;

    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACCESS,
        ST_PRIME,
        ST_LOAD,
        ST_SWEEP,
        ST_RESULT
    } t_state;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLEAR,
        OP_TAKE,
        OP_ACCESS,
        OP_PRIME,
        OP_LOAD,
        OP_SWEEP,
        OP_EMIT
    } t_dp_op;

    typedef struct packed {
        logic is_step;
        logic last_row;
    } t_dp_sts;

endpackage

// ===== hdl/life_grid_step.sv =====
// Life grid stepper (B3/S23): top level tying the controller to the datapath.
// Depends on lgs_pkg, lgs_ctrl and lgs_datapath.
//
// A grid of MAX_ROWS words of MAX_COLS cells sits in one memory. After reset a
// clearing pass writes every row dead, with the input stalled. Write, read and
// the unused command each pass through the access and result states. A step
// sweeps the memory one row per cycle (one read and one write port). One
// command is in flight at a time; a new command is taken while the previous
// result still waits at the output.
module life_grid_step #(
    parameter int MAX_ROWS = lgs_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = lgs_pkg::MAX_COLS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [lgs_pkg::CFG_IW-1:0]  i_cfg_index,
    input  logic [lgs_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [lgs_pkg::CMD_W-1:0]   i_command,
    input  logic [lgs_pkg::ROW_W-1:0]   i_cell_row,
    input  logic [lgs_pkg::COL_W-1:0]   i_cell_col,
    input  logic                        i_cell_value,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_read_value,
    output logic                        o_out_of_range
);
    import lgs_pkg::*;

    t_dp_op  dp_op;
    t_dp_sts dp_sts;

    lgs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (dp_sts),
        .o_op        (dp_op)
    );

    lgs_datapath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_op           (dp_op),
        .o_sts          (dp_sts),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_command      (i_command),
        .i_cell_row     (i_cell_row),
        .i_cell_col     (i_cell_col),
        .i_cell_value   (i_cell_value),
        .o_read_value   (o_read_value),
        .o_out_of_range (o_out_of_range)
    );

endmodule

// ===== hdl/lgs_datapath.sv =====
// Datapath of the life grid stepper: grid memory, config registers, row sweep
// registers, neighbor count logic and result registers.
// Depends on lgs_pkg.
module lgs_datapath #(
    parameter int MAX_ROWS = lgs_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = lgs_pkg::MAX_COLS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lgs_pkg::t_dp_op             i_op,
    output lgs_pkg::t_dp_sts            o_sts,
    input  logic                        i_cfg_we,
    input  logic [lgs_pkg::CFG_IW-1:0]  i_cfg_index,
    input  logic [lgs_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic [lgs_pkg::CMD_W-1:0]   i_command,
    input  logic [lgs_pkg::ROW_W-1:0]   i_cell_row,
    input  logic [lgs_pkg::COL_W-1:0]   i_cell_col,
    input  logic                        i_cell_value,
    output logic                        o_read_value,
    output logic                        o_out_of_range
);
    import lgs_pkg::*;

    localparam int AW  = $clog2(MAX_ROWS);
    localparam int RW  = (AW + 1 > CFG_W) ? AW + 1 : CFG_W;
    localparam int CIW = $clog2(MAX_COLS);

    logic [MAX_COLS-1:0] r_grid [MAX_ROWS];
    logic [MAX_COLS-1:0] r_q;

    logic [CFG_W-1:0]    r_grid_rows;
    logic [CFG_W-1:0]    r_grid_cols;
    logic [AW-1:0]       r_idx;
    logic [AW-1:0]       n_idx;

    logic [CMD_W-1:0]    r_cmd;
    logic [ROW_W-1:0]    r_row;
    logic [COL_W-1:0]    r_col;
    logic                r_val;

    logic [MAX_COLS-1:0] r_above;
    logic [MAX_COLS-1:0] r_cur;
    logic                r_res_read;
    logic                r_res_oor;
    logic                r_read_value;
    logic                r_out_of_range;

    logic [MAX_COLS-1:0] mask;
    logic [MAX_COLS-1:0] q_m;
    logic [MAX_COLS-1:0] below;
    logic [MAX_COLS-1:0] next_row;
    logic [MAX_COLS-1:0] wdata;
    logic [MAX_COLS-1:0] set_word;
    logic [AW-1:0]       raddr;
    logic [AW-1:0]       waddr;
    logic                re;
    logic                we;

    logic [RW-1:0]       idx_w;
    logic [RW-1:0]       idx_p1;
    logic [RW-1:0]       idx_p2;
    logic [RW-1:0]       rows_w;
    logic [RW-1:0]       in_row_w;
    logic [RW-1:0]       row_w;
    logic                row_ok;
    logic                col_ok;
    logic                in_grid;
    logic                below_ok;
    logic                cur_ok;
    logic                is_rw;

    assign idx_w    = RW'(r_idx);
    assign idx_p1   = idx_w + RW'(1);
    assign idx_p2   = idx_w + RW'(2);
    assign rows_w   = RW'(r_grid_rows);
    assign in_row_w = RW'(i_cell_row);
    assign row_w    = RW'(r_row);

    assign row_ok  = (row_w < rows_w) && (row_w < RW'(MAX_ROWS));
    assign col_ok  = (CFG_W'(r_col) < r_grid_cols) && (CFG_W'(r_col) < CFG_W'(MAX_COLS));
    assign in_grid = row_ok && col_ok;
    assign is_rw   = (r_cmd == CMD_WRITE) || (r_cmd == CMD_READ);

    assign below_ok = (idx_p1 < rows_w) && (idx_p1 < RW'(MAX_ROWS));
    assign cur_ok   = idx_w < rows_w;

    always_comb begin
        for (int c = 0; c < MAX_COLS; c++) begin
            mask[c] = CFG_W'(c) < r_grid_cols;
        end
    end

    assign q_m   = r_q & mask;
    assign below = below_ok ? q_m : '0;

    always_comb begin
        logic [MAX_COLS+1:0] pa;
        logic [MAX_COLS+1:0] pc;
        logic [MAX_COLS+1:0] pb;
        logic [3:0]          n;
        pa = {1'b0, r_above, 1'b0};
        pc = {1'b0, r_cur, 1'b0};
        pb = {1'b0, below, 1'b0};
        next_row = '0;
        for (int c = 0; c < MAX_COLS; c++) begin
            n = 4'($countones({pa[c], pa[c+1], pa[c+2], pc[c], pc[c+2],
                               pb[c], pb[c+1], pb[c+2]}));
            next_row[c] = (n == 4'd3) || (r_cur[c] && (n == 4'd2));
        end
        next_row = (cur_ok ? next_row : '0) & mask;
    end

    always_comb begin
        set_word = r_q;
        set_word[r_col[CIW-1:0]] = r_val;
    end

    always_comb begin
        re    = 1'b0;
        raddr = '0;
        we    = 1'b0;
        waddr = r_idx;
        wdata = '0;
        n_idx = r_idx;
        case (i_op)
            OP_CLEAR: begin
                we    = 1'b1;
                n_idx = o_sts.last_row ? '0 : r_idx + AW'(1);
            end
            OP_TAKE: begin
                re    = 1'b1;
                raddr = (in_row_w < RW'(MAX_ROWS)) ? in_row_w[AW-1:0] : '0;
            end
            OP_ACCESS: begin
                we    = in_grid && (r_cmd == CMD_WRITE);
                waddr = row_w[AW-1:0];
                wdata = set_word;
            end
            OP_PRIME: begin
                re    = 1'b1;
                n_idx = '0;
            end
            OP_LOAD: begin
                re    = 1'b1;
                raddr = idx_p1[AW-1:0];
            end
            OP_SWEEP: begin
                re    = 1'b1;
                raddr = (idx_p2 < RW'(MAX_ROWS)) ? idx_p2[AW-1:0] : '0;
                we    = 1'b1;
                wdata = next_row;
                n_idx = o_sts.last_row ? '0 : r_idx + AW'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_grid[waddr] <= wdata;
        end
        if (re) begin
            r_q <= r_grid[raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows <= CFG_RESET;
            r_grid_cols <= CFG_RESET;
            r_idx       <= '0;
        end else begin
            r_idx <= n_idx;
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_GRID_ROWS: r_grid_rows <= i_cfg_data;
                    CFG_GRID_COLS: r_grid_cols <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_TAKE: begin
                r_cmd <= i_command;
                r_row <= i_cell_row;
                r_col <= i_cell_col;
                r_val <= i_cell_value;
            end
            OP_ACCESS: begin
                r_res_read <= in_grid && (r_cmd == CMD_READ) && r_q[r_col[CIW-1:0]];
                r_res_oor  <= is_rw && !in_grid;
            end
            OP_PRIME: begin
                r_above    <= '0;
                r_res_read <= 1'b0;
                r_res_oor  <= 1'b0;
            end
            OP_LOAD: begin
                r_cur <= (rows_w != '0) ? q_m : '0;
            end
            OP_SWEEP: begin
                r_above <= r_cur;
                r_cur   <= below;
            end
            OP_EMIT: begin
                r_read_value   <= r_res_read;
                r_out_of_range <= r_res_oor;
            end
            default: begin
            end
        endcase
    end

    assign o_sts.is_step  = i_command == CMD_STEP;
    assign o_sts.last_row = r_idx == AW'(MAX_ROWS - 1);
    assign o_read_value   = r_read_value;
    assign o_out_of_range = r_out_of_range;

endmodule

// ===== hdl/lgs_ctrl.sv =====
// Controller of the life grid stepper: sequences the clearing pass, cell
// accesses and the generation sweep, and owns both handshakes.
// Depends on lgs_pkg.
module lgs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  lgs_pkg::t_dp_sts  i_sts,
    output lgs_pkg::t_dp_op   o_op
);
    import lgs_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_op        = OP_NONE;
        n_out_valid = r_out_valid && i_out_stall;
        unique case (r_state)
            ST_CLEAR: begin
                o_op = OP_CLEAR;
                if (i_sts.last_row) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_op    = OP_TAKE;
                    n_state = i_sts.is_step ? ST_PRIME : ST_ACCESS;
                end
            end
            ST_ACCESS: begin
                o_op    = OP_ACCESS;
                n_state = ST_RESULT;
            end
            ST_PRIME: begin
                o_op    = OP_PRIME;
                n_state = ST_LOAD;
            end
            ST_LOAD: begin
                o_op    = OP_LOAD;
                n_state = ST_SWEEP;
            end
            ST_SWEEP: begin
                o_op = OP_SWEEP;
                if (i_sts.last_row) begin
                    n_state = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_op        = OP_EMIT;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_in_stall  = r_state != ST_IDLE;
    assign o_out_valid = r_out_valid;

    a_result_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RESULT && r_out_valid && i_out_stall) |=> r_state == ST_RESULT)
        else $error("result emitted over a stalled transfer");

    a_sweep_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SWEEP && i_sts.last_row) |=> r_state == ST_RESULT)
        else $error("sweep did not end after last row");

    a_valid_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == ST_RESULT)
        else $error("output valid raised outside result state");

    a_step_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_in_valid && i_sts.is_step) |=> r_state == ST_PRIME)
        else $error("step transfer did not start a sweep");

endmodule
